[src/assert_macros.svh]
// Assertion macros shared by the token scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[src/jts_pkg.sv]
// Types and constants of the JSON token scanner.
`timescale 1ns / 1ps
package jts_pkg;

  localparam int unsigned ValueW = 31;
  localparam int unsigned ByteW  = 8;
  localparam logic [ValueW-1:0] ValueMax = {ValueW{1'b1}};

  localparam logic [ByteW-1:0] CharZero      = 8'h30;
  localparam logic [ByteW-1:0] CharNine      = 8'h39;
  localparam logic [ByteW-1:0] CharQuote     = 8'h22;
  localparam logic [ByteW-1:0] CharBackslash = 8'h5c;
  localparam logic [ByteW-1:0] CharLowerT    = 8'h74;
  localparam logic [ByteW-1:0] CharLowerN    = 8'h6e;
  localparam logic [ByteW-1:0] CharLowerR    = 8'h72;
  localparam logic [ByteW-1:0] CharOpenObj   = 8'h7b;
  localparam logic [ByteW-1:0] CharCloseObj  = 8'h7d;
  localparam logic [ByteW-1:0] CharOpenArr   = 8'h5b;
  localparam logic [ByteW-1:0] CharCloseArr  = 8'h5d;
  localparam logic [ByteW-1:0] CodeTab       = 8'h09;
  localparam logic [ByteW-1:0] CodeLineFeed  = 8'h0a;
  localparam logic [ByteW-1:0] CodeCarriage  = 8'h0d;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_STRING = 2'd2,
    MODE_ESCAPE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_INT       = 3'd0,
    KIND_STR_START = 3'd1,
    KIND_STR_CHAR  = 3'd2,
    KIND_STR_END   = 3'd3,
    KIND_OPEN_OBJ  = 3'd4,
    KIND_CLOSE_OBJ = 3'd5,
    KIND_OPEN_ARR  = 3'd6,
    KIND_CLOSE_ARR = 3'd7
  } kind_e;

  // Work for the back end produced by one input byte: an optional integer
  // beat followed by an optional second beat.
  typedef struct packed {
    logic              int_valid;
    logic [ValueW-1:0] num_value;
    logic              int_ovf;
    logic              sec_valid;
    kind_e             sec_kind;
    logic [ByteW-1:0]  sec_char;
  } jts_rec_t;

endpackage

[src/jts_front.sv]
// Front end: accepts bytes, tracks the scan mode and builds one record per byte.
`timescale 1ns / 1ps
module jts_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  logic [jts_pkg::ByteW-1:0] byte_in_i,
  output logic                     push_o,
  output jts_pkg::jts_rec_t        rec_o
);
  import jts_pkg::*;

  mode_e             mode_q, mode_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic              sat_q, sat_d;

  logic              is_digit;
  logic [3:0]        digit;
  logic [ValueW-1:0] acc_base;
  logic [ValueW+3:0] acc_next;

  function automatic logic struct_hit(input logic [ByteW-1:0] b);
    struct_hit = (b == CharQuote) || (b == CharOpenObj) || (b == CharCloseObj) ||
                 (b == CharOpenArr) || (b == CharCloseArr);
  endfunction

  function automatic kind_e struct_kind(input logic [ByteW-1:0] b);
    kind_e k;
    k = KIND_CLOSE_ARR;
    if (b == CharQuote) begin
      k = KIND_STR_START;
    end else if (b == CharOpenObj) begin
      k = KIND_OPEN_OBJ;
    end else if (b == CharCloseObj) begin
      k = KIND_CLOSE_OBJ;
    end else if (b == CharOpenArr) begin
      k = KIND_OPEN_ARR;
    end
    struct_kind = k;
  endfunction

  assign is_digit = (byte_in_i >= CharZero) && (byte_in_i <= CharNine);
  assign digit    = 4'(byte_in_i - CharZero);
  assign acc_base = (mode_q == MODE_NUMBER) ? acc_q : '0;
  assign acc_next = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0} +
                    (ValueW+4)'(digit);

  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    sat_d  = sat_q;
    case (mode_q)
      MODE_NUMBER, MODE_IDLE: begin
        if (is_digit) begin
          mode_d = MODE_NUMBER;
          sat_d  = (mode_q == MODE_NUMBER) ? sat_q : 1'b0;
          if (acc_next > (ValueW+4)'(ValueMax)) begin
            acc_d = ValueMax;
            sat_d = 1'b1;
          end else begin
            acc_d = acc_next[ValueW-1:0];
          end
        end else if (byte_in_i == CharQuote) begin
          mode_d = MODE_STRING;
        end else begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (byte_in_i == CharQuote) begin
          mode_d = MODE_IDLE;
        end else if (byte_in_i == CharBackslash) begin
          mode_d = MODE_ESCAPE;
        end
      end
      MODE_ESCAPE: begin
        mode_d = MODE_STRING;
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase
  end

  always_comb begin
    rec_o           = '0;
    rec_o.num_value = acc_q;
    rec_o.int_ovf   = sat_q;
    rec_o.sec_kind  = KIND_STR_CHAR;
    case (mode_q)
      MODE_NUMBER, MODE_IDLE: begin
        rec_o.int_valid = (mode_q == MODE_NUMBER) && !is_digit;
        rec_o.sec_valid = !is_digit && struct_hit(byte_in_i);
        rec_o.sec_kind  = struct_kind(byte_in_i);
      end
      MODE_STRING: begin
        if (byte_in_i == CharQuote) begin
          rec_o.sec_valid = 1'b1;
          rec_o.sec_kind  = KIND_STR_END;
        end else if (byte_in_i != CharBackslash) begin
          rec_o.sec_valid = 1'b1;
          rec_o.sec_char  = byte_in_i;
        end
      end
      MODE_ESCAPE: begin
        rec_o.sec_valid = 1'b1;
        if (byte_in_i == CharLowerT) begin
          rec_o.sec_char = CodeTab;
        end else if (byte_in_i == CharLowerN) begin
          rec_o.sec_char = CodeLineFeed;
        end else if (byte_in_i == CharLowerR) begin
          rec_o.sec_char = CodeCarriage;
        end else begin
          rec_o.sec_char = byte_in_i;
        end
      end
      default: begin
        rec_o.sec_valid = 1'b0;
      end
    endcase
    if (!rec_o.int_valid) begin
      rec_o.num_value = '0;
      rec_o.int_ovf   = 1'b0;
    end
  end

  assign push_o = fire_i && (rec_o.int_valid || rec_o.sec_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
      sat_q  <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      sat_q  <= sat_d;
    end
  end

endmodule

[src/jts_fifo.sv]
// Short register queue between the front end and the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jts_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o)
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && empty_o)
  `ASSERT_PROP(a_count_up, clk_i, rst_ni, push_i && !pop_i |=> count_q == $past(count_q) + 1'b1)

endmodule

[src/jts_back.sv]
// Back end: turns queued records into result beats through an output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jts_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  jts_pkg::jts_rec_t          head_i,
  input  logic                       head_valid_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 token_kind_o,
  output logic [jts_pkg::ValueW-1:0] number_value_o,
  output logic                       number_overflow_o,
  output logic [jts_pkg::ByteW-1:0]  string_char_o,
  output logic                       last_of_run_o
);
  import jts_pkg::*;

  logic              valid_q, valid_d;
  logic              phase_q, phase_d;
  kind_e             kind_q, kind_d;
  logic [ValueW-1:0] value_q, value_d;
  logic              ovf_q, ovf_d;
  logic [ByteW-1:0]  char_q, char_d;
  logic              last_q, last_d;
  logic              load;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    kind_d  = kind_q;
    value_d = value_q;
    ovf_d   = ovf_q;
    char_d  = char_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        if (head_i.int_valid && !phase_q) begin
          kind_d  = KIND_INT;
          value_d = head_i.num_value;
          ovf_d   = head_i.int_ovf;
          char_d  = '0;
          last_d  = !head_i.sec_valid;
          phase_d = head_i.sec_valid;
          pop_o   = !head_i.sec_valid;
        end else begin
          kind_d  = head_i.sec_kind;
          value_d = '0;
          ovf_d   = 1'b0;
          char_d  = head_i.sec_char;
          last_d  = 1'b1;
          phase_d = 1'b0;
          pop_o   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
    ovf_q   <= ovf_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  assign out_valid_o       = valid_q;
  assign token_kind_o      = kind_q;
  assign number_value_o    = value_q;
  assign number_overflow_o = ovf_q;
  assign string_char_o     = char_q;
  assign last_of_run_o     = last_q;

  `ASSERT_PROP(a_phase_head, clk_i, rst_ni, phase_q |-> head_valid_i)
  `ASSERT_PROP(a_phase_beat, clk_i, rst_ni, phase_q |-> valid_q && !last_q)
  `ASSERT_PROP(a_first_is_int, clk_i, rst_ni, valid_q && !last_q |-> kind_q == KIND_INT)

endmodule

[src/json_token_scanner.sv]
// Top level of the streaming JSON token scanner.
`timescale 1ns / 1ps
// The scanner takes one text byte per beat and can accept a byte in every
// cycle while the queue is not full. A byte gives zero, one or two result
// beats: a digit run ends in an integer beat that is followed by the beat
// of the byte that ended it, if it has one. The front end classifies bytes
// and writes one record per byte that has results into a queue of FifoDepth
// entries; the back end drains it through a single output register at one
// result beat per cycle unless the output stalls. The sustained rate is
// one byte per cycle unless the output stalls or many structural bytes
// end numbers: the output port paces their two beats, the queue absorbs
// short bursts. A byte's record passes the queue, then the output register.
module json_token_scanner #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_kind_o,
  output logic [30:0] number_value_o,
  output logic        number_overflow_o,
  output logic [7:0]  string_char_o,
  output logic        last_of_run_o
);
  import jts_pkg::*;

  logic     fire;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;
  jts_rec_t rec_in;
  jts_rec_t rec_head;

  assign in_stall_o = full;
  assign fire       = in_valid_i && !full;

  jts_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .byte_in_i (byte_in_i),
    .push_o    (push),
    .rec_o     (rec_in)
  );

  jts_fifo #(
    .Width ($bits(jts_rec_t)),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (rec_in),
    .pop_i   (pop),
    .rdata_o (rec_head),
    .empty_o (empty),
    .full_o  (full)
  );

  jts_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (rec_head),
    .head_valid_i      (!empty),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .token_kind_o      (token_kind_o),
    .number_value_o    (number_value_o),
    .number_overflow_o (number_overflow_o),
    .string_char_o     (string_char_o),
    .last_of_run_o     (last_of_run_o)
  );

endmodule
